[hdl/cas_pkg.sv]
// shared types, constants and codes of the channel alarm supervisor
package cas_pkg;

	// channel table geometry
	localparam int CHANNELS = 8;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_W     = 3;
	localparam int MAX_RES  = 8;
	localparam int CNT_W    = $clog2(MAX_RES + 1);

	// configuration port geometry
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic [1:0] CMD_LEVEL = 2'd0;
	localparam logic [1:0] CMD_BEAT  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_DOWNLINK = 2'd0;
	localparam logic [1:0] KIND_ALIVE    = 2'd1;
	localparam logic [1:0] KIND_FAULT    = 2'd2;

	// risk levels
	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_WARN   = 2'd1;
	localparam logic [1:0] LVL_DANGER = 2'd2;

	// indicator bit positions
	localparam int IND_RED    = 2;
	localparam int IND_YELLOW = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCALATE      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MISSED_BEATS  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NO_DIST_CODE  = 8'd3;

	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]         command;
		logic [CH_W-1:0]    channel;
		logic [1:0]         level;
		logic signed [63:0] timestamp;
		logic [15:0]        distance;
		logic [4:0]         indicators;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [CH_W-1:0]    out_channel;
		logic [1:0]         out_level;
		logic signed [63:0] out_timestamp;
		logic [15:0]        out_distance;
		logic               alive;
		logic [4:0]         out_indicators;
		logic               faulted;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  retry_limit;
		logic        escalate_enable;
		logic [15:0] missed_beats;
		logic [15:0] no_distance_code;
	} cfg_t;

	// one channel's table entry, all zero after reset
	typedef struct packed {
		logic        sent_valid;
		logic [1:0]  sent_level;
		logic [7:0]  retry_count;
		logic        fault_flag;
		logic        alive_flag;
		logic [4:0]  seen_indicators;
		logic [15:0] beat_age;
	} chan_rec_t;

endpackage

[hdl/cas_cfg_regs.sv]
// configuration register bank of the channel alarm supervisor
module cas_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data,
	output cas_pkg::cfg_t                  cfg
);
	import cas_pkg::*;

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// register write on a completed transfer, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit      <= 8'd3;
			cfg_q.escalate_enable  <= 1'b1;
			cfg_q.missed_beats     <= 16'd3;
			cfg_q.no_distance_code <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RETRY_LIMIT:  cfg_q.retry_limit      <= cfg_data[7:0];
				REG_ESCALATE:     cfg_q.escalate_enable  <= cfg_data[0];
				REG_MISSED_BEATS: cfg_q.missed_beats     <= cfg_data;
				REG_NO_DIST_CODE: cfg_q.no_distance_code <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/cas_chan_ram.sv]
// channel table memory with one read and one write port and entry valid bits
module cas_chan_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [cas_pkg::CH_AW-1:0] rd_addr,
	output cas_pkg::chan_rec_t        rd_data,
	input  logic                      wr_en,
	input  logic [cas_pkg::CH_AW-1:0] wr_addr,
	input  cas_pkg::chan_rec_t        wr_data
);
	import cas_pkg::*;

	chan_rec_t             mem [CHANNELS];
	chan_rec_t             rd_q;
	logic                  rd_vld_q;
	logic [CHANNELS-1:0]   vld_q;

	// storage array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// entry valid bits, an unwritten entry reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[hdl/channel_alarm_supervisor_unit.sv]
// channel alarm supervisor: command sequencer around the channel table memory
// level request or heartbeat: busy in the lookup and execute states, and in flush when a
// heartbeat gives two results; strobes registered in execute, and in flush for a second one
// tick: busy in scan, drain and flush, one table entry read and written back per cycle;
// each death waits for the next death or flush, and no result can be stalled by the receiver
// reset clears configuration to defaults and marks every table entry as all zero
module channel_alarm_supervisor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  cas_pkg::in_item_t              item,
	output cas_pkg::out_item_t             result,
	output logic                           result_strobe,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cas_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	cfg_t              cfg;
	logic [2:0]        state_q;
	in_item_t          item_q;
	logic [CH_AW-1:0]  scan_q;
	logic [CNT_W-1:0]  dcnt_q;
	logic              v_s1;
	logic [CH_AW-1:0]  ch_s1;
	out_item_t         out_q;
	logic              strobe_q;
	out_item_t         pend_q;
	logic              pend_v_q;

	logic              rd_en;
	logic [CH_AW-1:0]  rd_addr;
	chan_rec_t         rec;
	logic              wr_en;
	logic [CH_AW-1:0]  wr_addr;
	chan_rec_t         wr_data;

	logic              chan_ok;
	logic [CH_AW-1:0]  chan_idx;
	logic [1:0]        rep;
	chan_rec_t         xrec;
	logic              x_wr;
	logic              has_a;
	logic              has_b;
	out_item_t         res_a;
	out_item_t         res_b;
	chan_rec_t         trec;
	logic [15:0]       age_inc;
	logic              die;
	out_item_t         res_t;
	out_item_t         pend_fin;
	logic              strobe_d;

	cas_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cas_chan_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rec),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign busy          = (state_q != ST_IDLE);
	assign result        = out_q;
	assign result_strobe = strobe_q;

	assign chan_ok  = int'(item_q.channel) < CHANNELS;
	assign chan_idx = CH_AW'(item_q.channel);

	// reported level from the indicator bits
	always_comb begin
		priority if (item_q.indicators[IND_RED]) begin
			rep = LVL_DANGER;
		end else if (item_q.indicators[IND_YELLOW]) begin
			rep = LVL_WARN;
		end else begin
			rep = LVL_NONE;
		end
	end

	// request and heartbeat update of the addressed entry
	always_comb begin
		xrec  = rec;
		x_wr  = 1'b0;
		has_a = 1'b0;
		has_b = 1'b0;
		res_a = '0;
		res_b = '0;
		res_a.out_channel = item_q.channel;
		res_b.out_channel = item_q.channel;
		if (item_q.command == CMD_LEVEL) begin
			if (chan_ok && item_q.level <= LVL_DANGER &&
			    !(rec.sent_valid && rec.sent_level == item_q.level)) begin
				x_wr              = 1'b1;
				xrec.sent_valid   = 1'b1;
				xrec.sent_level   = item_q.level;
				xrec.retry_count  = 8'd0;
				has_a             = 1'b1;
				res_a.kind          = KIND_DOWNLINK;
				res_a.out_level     = item_q.level;
				res_a.out_timestamp = item_q.timestamp;
				res_a.out_distance  = item_q.distance;
			end
		end else if (item_q.command == CMD_BEAT && chan_ok) begin
			x_wr                 = 1'b1;
			xrec.beat_age        = 16'd0;
			xrec.alive_flag      = 1'b1;
			xrec.seen_indicators = item_q.indicators;
			has_a                = !rec.alive_flag || rec.seen_indicators != item_q.indicators;
			res_a.kind           = KIND_ALIVE;
			res_a.alive          = 1'b1;
			res_a.out_indicators = item_q.indicators;
			if (rec.sent_valid) begin
				priority if (rep == rec.sent_level) begin
					xrec.retry_count = 8'd0;
					if (rec.fault_flag) begin
						xrec.fault_flag = 1'b0;
						has_b           = 1'b1;
						res_b.kind      = KIND_FAULT;
					end
				end else if (rec.retry_count < cfg.retry_limit) begin
					xrec.retry_count    = rec.retry_count + 8'd1;
					has_b               = 1'b1;
					res_b.kind          = KIND_DOWNLINK;
					res_b.out_level     = rec.sent_level;
					res_b.out_timestamp = item_q.timestamp;
					res_b.out_distance  = cfg.no_distance_code;
				end else if (cfg.escalate_enable && !rec.fault_flag) begin
					xrec.fault_flag = 1'b1;
					has_b           = 1'b1;
					res_b.kind      = KIND_FAULT;
					res_b.faulted   = 1'b1;
				end
			end
		end
		// the second result, when there is one, closes the item
		res_a.last = !has_b;
		res_b.last = 1'b1;
	end

	// tick ageing of the entry in the scan stage
	always_comb begin
		trec    = rec;
		die     = 1'b0;
		res_t   = '0;
		age_inc = (rec.beat_age != AGE_MAX) ? rec.beat_age + 16'd1 : rec.beat_age;
		if (rec.alive_flag) begin
			trec.beat_age = age_inc;
			if (age_inc > cfg.missed_beats && dcnt_q < CNT_W'(MAX_RES)) begin
				trec.alive_flag = 1'b0;
				die             = 1'b1;
			end
		end
		res_t.kind           = KIND_ALIVE;
		res_t.out_channel    = CH_W'(ch_s1);
		res_t.out_indicators = rec.seen_indicators;
	end

	// held result as the final one of its item
	always_comb begin
		pend_fin      = pend_q;
		pend_fin.last = 1'b1;
	end

	// result strobe for the next cycle
	assign strobe_d = (state_q == ST_EXEC && (has_a || has_b)) ||
	                  (v_s1 && die && pend_v_q) ||
	                  (state_q == ST_FLUSH && pend_v_q);

	// memory port steering: scan stage and single item never overlap
	assign rd_en   = (state_q == ST_LOOK) || (state_q == ST_SCAN);
	assign rd_addr = (state_q == ST_SCAN) ? scan_q : chan_idx;
	assign wr_en   = v_s1 || (state_q == ST_EXEC && x_wr);
	assign wr_addr = v_s1 ? ch_s1 : chan_idx;
	assign wr_data = v_s1 ? trec : xrec;

	// sequencer, scan stage and result holding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scan_q   <= '0;
			dcnt_q   <= '0;
			v_s1     <= 1'b0;
			strobe_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			v_s1     <= (state_q == ST_SCAN);
			if (v_s1 && die) begin
				dcnt_q   <= dcnt_q + CNT_W'(1);
				pend_v_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.command == CMD_TICK) begin
							state_q <= ST_SCAN;
							scan_q  <= '0;
							dcnt_q  <= '0;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (has_a && has_b) begin
						pend_v_q <= 1'b1;
						state_q  <= ST_FLUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_q == CH_AW'(CHANNELS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + CH_AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					pend_v_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers of the item, scan stage and results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= item;
		end
		if (state_q == ST_SCAN) begin
			ch_s1 <= scan_q;
		end
		if (state_q == ST_EXEC) begin
			if (has_a) begin
				out_q  <= res_a;
				pend_q <= res_b;
			end else if (has_b) begin
				out_q <= res_b;
			end
		end else if (v_s1 && die) begin
			pend_q <= res_t;
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end else if (state_q == ST_FLUSH && pend_v_q) begin
			out_q <= pend_fin;
		end
	end

`ifndef SYNTHESIS
	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command == CMD_TICK |=> state_q == ST_SCAN)
		else $error("tick transfer did not start the table scan");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> busy)
		else $error("held result left behind while idle");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && rd_en |-> wr_addr != rd_addr)
		else $error("table read and write hit the same entry");
`endif

endmodule
